>>> sv/plc_pkg.sv
`timescale 1ns / 1ps

package plc_pkg;

  // Operating mode of the lock
  typedef enum logic [2:0] {
    MODE_FIRST = 3'd0,
    MODE_MENU  = 3'd1,
    MODE_LOGIN = 3'd2,
    MODE_OLD   = 3'd3,
    MODE_NEW   = 3'd4
  } mode_e;

  // Event reported with every result
  typedef enum logic [2:0] {
    EV_IGNORED = 3'd0,
    EV_DIGIT   = 3'd1,
    EV_SAVED   = 3'd2,
    EV_UNLOCK  = 3'd3,
    EV_OLD_OK  = 3'd4,
    EV_RETRY   = 3'd5,
    EV_ALARM   = 3'd6,
    EV_MENU    = 3'd7
  } event_e;

  localparam logic [7:0] CharChange = 8'h31; // '1'
  localparam logic [7:0] CharLogin  = 8'h32; // '2'
  localparam logic [7:0] CharZero   = 8'h30; // '0'

  localparam logic [3:0] MaxTriesReset = 4'd3;

  localparam int unsigned RxW      = 8;
  localparam int unsigned DigitsW  = 5;
  localparam int unsigned WrongW   = 4;
  localparam int unsigned OutDataW = 24;

endpackage

>>> sv/pin_lock_controller_core.sv
`timescale 1ns / 1ps

// PIN lock controller.
//
// Slave stream: one received character per transfer in s_axis_tdata[7:0].
// After reset the first PIN_LENGTH characters set the stored PIN (which
// resets to all ASCII '0'). In the menu '1' starts a PIN change, '2' starts
// a login; every other character is ignored. Login and old-PIN entry collect
// PIN_LENGTH characters and compare them with the stored PIN.
// Master stream: exactly one result transfer per input transfer, in order,
// carrying the event code, unlock/alarm pulses, the new mode, the digit
// count and the wrong-try count.
// Configuration: cfg_we_i writes max_wrong_tries (reset 3, 0 acts as 1);
// only write it while no transfer is in flight.
//
// Structure: input register, then the decode/compare logic and state
// update into the result register.
// Throughput: one character per cycle while the master stream does not
// stall.
// A stalled master holds the result register; the input register still
// takes one more character, after which s_axis_tready drops until the
// result is taken. Reset empties both registers and restores the state.
module pin_lock_controller_core #(
  parameter int unsigned PIN_LENGTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_we_i,
  input  logic [3:0]                    cfg_wdata_i,   // max_wrong_tries
  // Slave stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  // Master stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] event_res, [3] unlock, [4] alarm, [7:5] mode_now,
  // [12:8] digits_entered, [16:13] wrong_count, [23:17] zero
  output logic [plc_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned IdxW = (PIN_LENGTH > 1) ? $clog2(PIN_LENGTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PIN_LENGTH - 1);

  // Pipeline control
  logic                     in_vld_q;
  logic [plc_pkg::RxW-1:0]  in_byte_q;
  logic                     out_vld_q;
  logic [plc_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                     adv;

  // Lock state
  plc_pkg::mode_e           mode_q, mode_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [plc_pkg::WrongW-1:0] wrong_q, wrong_d;
  logic [3:0]               max_tries_q;
  logic [7:0]               pin_q   [PIN_LENGTH];
  logic [7:0]               pin_d   [PIN_LENGTH];
  logic [7:0]               entry_q [PIN_LENGTH];
  logic [7:0]               entry_d [PIN_LENGTH];

  plc_pkg::event_e          ev;
  logic                     last_digit;
  logic                     match;
  logic [plc_pkg::WrongW:0] wrong_inc;
  logic [plc_pkg::WrongW:0] limit;

  // The item in the input register moves on when the result slot is free
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  assign last_digit = (idx_q == LastIdx);
  assign wrong_inc  = {1'b0, wrong_q} + 5'd1;
  assign limit      = (max_tries_q == 4'd0) ? 5'd1 : {1'b0, max_tries_q};

  // Full-PIN compare; the current byte stands in for the final position
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < PIN_LENGTH; i++) begin
      if (i == PIN_LENGTH - 1) begin
        match = match && (in_byte_q == pin_q[i]);
      end else begin
        match = match && (entry_q[i] == pin_q[i]);
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    idx_d   = idx_q;
    wrong_d = wrong_q;
    pin_d   = pin_q;
    entry_d = entry_q;
    ev      = plc_pkg::EV_IGNORED;
    unique case (mode_q)
      plc_pkg::MODE_FIRST, plc_pkg::MODE_NEW: begin
        pin_d[idx_q] = in_byte_q;
        if (last_digit) begin
          idx_d  = '0;
          mode_d = plc_pkg::MODE_MENU;
          ev     = plc_pkg::EV_SAVED;
        end else begin
          idx_d = idx_q + 1'b1;
          ev    = plc_pkg::EV_DIGIT;
        end
      end
      plc_pkg::MODE_MENU: begin
        idx_d = '0;
        priority if (in_byte_q == plc_pkg::CharChange) begin
          mode_d = plc_pkg::MODE_OLD;
          ev     = plc_pkg::EV_MENU;
        end else if (in_byte_q == plc_pkg::CharLogin) begin
          mode_d = plc_pkg::MODE_LOGIN;
          ev     = plc_pkg::EV_MENU;
        end else begin
          ev = plc_pkg::EV_IGNORED;
        end
      end
      plc_pkg::MODE_LOGIN, plc_pkg::MODE_OLD: begin
        entry_d[idx_q] = in_byte_q;
        if (!last_digit) begin
          idx_d = idx_q + 1'b1;
          ev    = plc_pkg::EV_DIGIT;
        end else begin
          idx_d = '0;
          priority if (match && mode_q == plc_pkg::MODE_LOGIN) begin
            wrong_d = '0;
            mode_d  = plc_pkg::MODE_MENU;
            ev      = plc_pkg::EV_UNLOCK;
          end else if (match) begin
            mode_d = plc_pkg::MODE_NEW;
            ev     = plc_pkg::EV_OLD_OK;
          end else if (wrong_inc >= limit) begin
            // try limit reached: alarm and back to the menu
            wrong_d = '0;
            mode_d  = plc_pkg::MODE_MENU;
            ev      = plc_pkg::EV_ALARM;
          end else begin
            // wrong PIN, same entry again
            wrong_d = wrong_inc[plc_pkg::WrongW-1:0];
            ev      = plc_pkg::EV_RETRY;
          end
        end
      end
      default: begin
        mode_d = plc_pkg::MODE_MENU;
        idx_d  = '0;
      end
    endcase
  end

  always_comb begin
    out_data_d        = '0;
    out_data_d[2:0]   = ev;
    out_data_d[3]     = (ev == plc_pkg::EV_UNLOCK);
    out_data_d[4]     = (ev == plc_pkg::EV_ALARM);
    out_data_d[7:5]   = mode_d;
    out_data_d[12:8]  = plc_pkg::DigitsW'(idx_d);
    out_data_d[16:13] = wrong_d;
  end

  // Control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      mode_q      <= plc_pkg::MODE_FIRST;
      idx_q       <= '0;
      wrong_q     <= '0;
      max_tries_q <= plc_pkg::MaxTriesReset;
      for (int i = 0; i < PIN_LENGTH; i++) begin
        pin_q[i] <= plc_pkg::CharZero;
      end
    end else begin
      if (cfg_we_i) begin
        max_tries_q <= cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        mode_q    <= mode_d;
        idx_q     <= idx_d;
        wrong_q   <= wrong_d;
        pin_q     <= pin_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (adv) begin
      out_data_q <= out_data_d;
      entry_q    <= entry_d;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIdx)
    else $error("digit index beyond PIN length");

  a_unlock_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_data_q[3] == (out_data_q[2:0] == plc_pkg::EV_UNLOCK)))
    else $error("unlock pulse does not match event");

  a_alarm_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_data_q[4]) |->
      (out_data_q[16:13] == '0 && out_data_q[7:5] == plc_pkg::MODE_MENU))
    else $error("alarm without cleared count and menu return");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced item produced no result");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> out_vld_q)
    else $error("stalled result dropped");

endmodule

>>> verif/pin_lock_controller_core_tb.sv
`timescale 1ns / 1ps

module pin_lock_controller_core_tb;

  localparam int unsigned PinLen    = 4;
  localparam int unsigned StallMax  = 14;
  localparam int unsigned HoldOff   = 200;   // long receiver stall, fills the pipe
  localparam int unsigned TailWait  = 10;    // pipeline drain plus margin
  localparam int unsigned IdleLimit = 2000;  // cycles without any transfer

  typedef struct {
    plc_pkg::event_e ev;
    logic            unlock;
    logic            alarm;
    plc_pkg::mode_e  mode;
    logic [4:0]      digits;
    logic [3:0]      wrong;
  } lock_result_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [3:0]                    cfg_wdata_i   = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [plc_pkg::OutDataW-1:0]  m_axis_tdata;

  // Lock state as predicted from the accepted input transfers
  plc_pkg::mode_e lk_mode  = plc_pkg::MODE_FIRST;
  logic [4:0]     lk_idx   = '0;
  logic [7:0]     lk_entry [PinLen];
  logic [7:0]     lk_pin   [PinLen] = '{default: plc_pkg::CharZero};
  logic [3:0]     lk_wrong = '0;
  logic [3:0]     lk_limit = plc_pkg::MaxTriesReset;

  lock_result_t pending_results [$];
  int          error_count    = 0;
  int          decisive_items = 0;   // transfers that were not ignored
  bit          no_idle        = 1'b0;
  int          hold_off       = 0;
  int          bad_pos        = -1;  // wrong digit planned for the current entry
  int          idle_cycles    = 0;

  pin_lock_controller_core #(
    .PIN_LENGTH (PinLen)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one accepted byte to the predicted lock and queue the result
  task automatic lock_step(input logic [7:0] b);
    lock_result_t res;
    int           idx;
    int           next;
    int           lim;
    bit           same;
    res.ev = plc_pkg::EV_IGNORED;
    idx    = (lk_idx >= PinLen) ? 0 : lk_idx;
    case (lk_mode)
      plc_pkg::MODE_FIRST, plc_pkg::MODE_NEW: begin
        lk_pin[idx] = b;
        idx++;
        if (idx >= PinLen) begin
          idx     = 0;
          lk_mode = plc_pkg::MODE_MENU;
          res.ev  = plc_pkg::EV_SAVED;
        end else begin
          res.ev = plc_pkg::EV_DIGIT;
        end
      end
      plc_pkg::MODE_MENU: begin
        if (b == plc_pkg::CharChange) begin
          lk_mode = plc_pkg::MODE_OLD;
          res.ev  = plc_pkg::EV_MENU;
        end else if (b == plc_pkg::CharLogin) begin
          lk_mode = plc_pkg::MODE_LOGIN;
          res.ev  = plc_pkg::EV_MENU;
        end
        idx = 0;
      end
      plc_pkg::MODE_LOGIN, plc_pkg::MODE_OLD: begin
        lk_entry[idx] = b;
        idx++;
        if (idx < PinLen) begin
          res.ev = plc_pkg::EV_DIGIT;
        end else begin
          idx  = 0;
          same = 1'b1;
          for (int i = 0; i < PinLen; i++) begin
            if (lk_entry[i] != lk_pin[i]) same = 1'b0;
          end
          if (same && lk_mode == plc_pkg::MODE_LOGIN) begin
            lk_wrong = '0;
            lk_mode  = plc_pkg::MODE_MENU;
            res.ev   = plc_pkg::EV_UNLOCK;
          end else if (same) begin
            // correct old PIN keeps the wrong-try count
            lk_mode = plc_pkg::MODE_NEW;
            res.ev  = plc_pkg::EV_OLD_OK;
          end else begin
            next = lk_wrong + 1;
            lim  = (lk_limit == 0) ? 1 : lk_limit;  // zero limit acts as one
            if (next >= lim) begin
              lk_wrong = '0;
              lk_mode  = plc_pkg::MODE_MENU;
              res.ev   = plc_pkg::EV_ALARM;
            end else begin
              lk_wrong = next[3:0];
              res.ev   = plc_pkg::EV_RETRY;
            end
          end
        end
      end
      default: begin
        lk_mode = plc_pkg::MODE_MENU;
        idx     = 0;
      end
    endcase
    lk_idx     = idx[4:0];
    res.unlock = (res.ev == plc_pkg::EV_UNLOCK);
    res.alarm  = (res.ev == plc_pkg::EV_ALARM);
    res.mode   = lk_mode;
    res.digits = lk_idx;
    res.wrong  = lk_wrong;
    pending_results.push_back(res);
    if (res.ev != plc_pkg::EV_IGNORED) decisive_items++;
  endtask

  // Offer one byte after a random gap (none when no_idle is set); returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, StallMax);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = b;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    lock_step(b);
    @(negedge clk_i);
  endtask

  // Sender pause: wait until every predicted result has been seen
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [3:0] v);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    lk_limit = v;
  endtask

  // Mostly well-formed sessions driven by the predicted state, some noise
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    case (lk_mode)
      plc_pkg::MODE_MENU: begin
        if (r < 40) return plc_pkg::CharLogin;
        if (r < 75) return plc_pkg::CharChange;
        return 8'($urandom_range(0, 255));
      end
      plc_pkg::MODE_LOGIN, plc_pkg::MODE_OLD: begin
        if (lk_idx == 0) begin
          if (r < 55)      bad_pos = -1;
          else if (r < 90) bad_pos = $urandom_range(0, PinLen - 1);
          else             bad_pos = -2;
        end
        if (bad_pos == -2) return 8'($urandom_range(0, 255));
        if (bad_pos == lk_idx) return lk_pin[lk_idx] ^ 8'($urandom_range(1, 255));
        return lk_pin[lk_idx];
      end
      default: begin
        if (r < 70) return plc_pkg::CharZero + 8'($urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  task automatic send_entry(input bit correct);
    for (int i = 0; i < PinLen; i++) begin
      send_byte((correct || i != PinLen - 1) ? lk_pin[i] : lk_pin[i] ^ 8'h5A);
    end
  endtask

  // Directed: first PIN uses the byte extremes and both menu characters
  task automatic test_first_set();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(plc_pkg::CharChange);
    send_byte(plc_pkg::CharLogin);
  endtask

  task automatic test_menu_ignore();
    send_byte(8'h41);
  endtask

  // Wrong old PIN retries, then the correct one leads to new PIN entry
  task automatic test_pin_change();
    logic [7:0] fresh [PinLen];
    fresh = '{8'h39, 8'h80, 8'h7F, 8'h01};
    send_byte(plc_pkg::CharChange);
    send_entry(1'b0);
    send_entry(1'b1);
    for (int i = 0; i < PinLen; i++) send_byte(fresh[i]);
  endtask

  // Correct login with one wrong try pending, so the count clears
  task automatic test_login_unlock();
    send_byte(plc_pkg::CharLogin);
    send_entry(1'b1);
  endtask

  task automatic test_zero_limit_alarm();
    write_limit(4'd0);
    send_byte(plc_pkg::CharLogin);
    send_entry(1'b0);
  endtask

  // Limit of 15: fourteen retries then the alarm
  task automatic test_max_limit();
    write_limit(4'd15);
    send_byte(plc_pkg::CharLogin);
    repeat (15) begin
      bad_pos = $urandom_range(0, PinLen - 1);
      for (int i = 0; i < PinLen; i++) begin
        send_byte((i == bad_pos) ? lk_pin[i] ^ 8'($urandom_range(1, 255)) : lk_pin[i]);
      end
    end
  endtask

  task automatic test_random_sessions();
    logic [3:0] limits [6];
    int         start;
    limits = '{4'd1, 4'd3, 4'd15, 4'd2, 4'd4, 4'($urandom_range(0, 15))};
    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      no_idle = p[0];
      start   = decisive_items;
      while (decisive_items - start < 100) send_byte(pick_byte());
    end
    no_idle = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    no_idle  = 1'b1;
    hold_off = HoldOff;
    repeat (24) send_byte(pick_byte());
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_first_set();
    test_menu_ignore();
    test_pin_change();
    test_login_unlock();
    test_zero_limit_alarm();
    test_max_limit();
    test_random_sessions();
    test_backpressure();
    wait_drained();
    repeat (TailWait) @(negedge clk_i);
    if (error_count == 0) begin
      $display("PASS pin_lock_controller_core");
    end else begin
      $display("FAIL pin_lock_controller_core");
    end
    $finish;
  end

  // Result receiver with random stalls and the occasional long hold-off
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_off > 0) begin
        stall    = hold_off;
        hold_off = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, StallMax);
      end
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Compare every result transfer with the oldest prediction
  always @(posedge clk_i) begin
    lock_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no prediction waiting: %0h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_res", 8'(want.ev), 8'(m_axis_tdata[2:0]));
        check_field("unlock", 8'(want.unlock), 8'(m_axis_tdata[3]));
        check_field("alarm", 8'(want.alarm), 8'(m_axis_tdata[4]));
        check_field("mode_now", 8'(want.mode), 8'(m_axis_tdata[7:5]));
        check_field("digits_entered", 8'(want.digits), 8'(m_axis_tdata[12:8]));
        check_field("wrong_count", 8'(want.wrong), 8'(m_axis_tdata[16:13]));
        check_field("padding", 8'h00, 8'(m_axis_tdata[23:17]));
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL pin_lock_controller_core");
      $finish;
    end
  end

endmodule
